// ----- rtl/pcd_pkg.sv -----
`timescale 1ns / 1ps
package pcd_pkg;
    localparam int MAX_VECTORS = 32;
    localparam int MAX_DIM     = 256;
    localparam int ROW_CAP     = 32;
    localparam int ROW_LIM     = (MAX_VECTORS < ROW_CAP) ? MAX_VECTORS : ROW_CAP;

    localparam int VEC_AW    = $clog2(MAX_VECTORS);
    localparam int DIM_AW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int MEM_AW    = VEC_AW + DIM_AW;
    localparam int MEM_DEPTH = 1 << MEM_AW;
    localparam int DCNT_W    = $clog2(MAX_DIM + 1);

    localparam int NORM_W = 31 + $clog2(MAX_DIM);
    localparam int DOT_W  = NORM_W + 1;
    localparam int SQ_W   = (NORM_W + 1) / 2;
    localparam int SQV_W  = 2 * SQ_W;
    localparam int SQK_W  = $clog2(SQ_W);
    localparam int DEN_W  = 2 * SQ_W;
    localparam int WIDE_W = NORM_W + 17;

    localparam int QBITS = 14;
    localparam int QK_W  = 4;
    localparam logic [15:0] ONE_Q14 = 16'd16384;

    localparam logic REG_MODEL_COUNT = 1'b0;
    localparam logic REG_DIM_COUNT   = 1'b1;
endpackage

// ----- rtl/pcd_sqrt.sv -----
`timescale 1ns / 1ps
module pcd_sqrt import pcd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NORM_W-1:0] i_value,
    output logic              o_done,
    output logic [SQ_W-1:0]   o_root
);
    logic             r_busy;
    logic             r_done;
    logic [SQV_W-1:0] r_v;
    logic [SQV_W-1:0] r_res;
    logic [SQK_W-1:0] r_k;
    logic [SQV_W-1:0] bitv;
    logic [SQV_W-1:0] trial;

    assign bitv  = SQV_W'(1) << {r_k, 1'b0};
    assign trial = r_res + bitv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_v    <= SQV_W'(i_value);
                r_res  <= '0;
                r_k    <= SQK_W'(SQ_W - 1);
            end else if (r_busy) begin
                if (r_v >= trial) begin
                    r_v   <= r_v - trial;
                    r_res <= (r_res >> 1) + bitv;
                end else begin
                    r_res <= r_res >> 1;
                end
                if (r_k == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_k <= r_k - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[SQ_W-1:0];
endmodule

// ----- rtl/pairwise_cosine_distance_unit.sv -----
`timescale 1ns / 1ps
// pairwise cosine distance unit
// slave stream: tuser selects the kind of transfer, 0 loads one element
// (tdata: vec_index, dim_index, elem_value) into the vector store, 1 requests
// the distance row of vector vec_index.
// master stream: one transfer per stored vector j below model_count (0 read as 1,
// capped at 32), tdata carries col_index and distance (Q2.14), tlast marks the row end.
// each distance runs a multiply-accumulate over dim_count elements (0 read as 1)
// (two store reads and three products per cycle), two square roots
// on the shared root unit, one multiply, one setup and a bit-serial divide;
// a zero norm skips straight to distance 1.0. tready stays low for the whole row.
// a request for a vector at or above the effective model_count produces nothing.
// the result register decouples the sides: the next column is computed while
// a result waits; with the receiver stalled the sequencer holds at the end
// of the following column. reset restores model_count 32 and dim_count 256
// and empties the result register; the store is not cleared and must be
// loaded before it is used.
module pairwise_cosine_distance_unit import pcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // vec_index, dim_index, elem_value
    input  logic        i_s_axis_tuser,  // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,  // col_index, distance
    output logic        o_m_axis_tlast,  // last_in_row
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MAC  = 4'd1;
    localparam logic [3:0] S_SQI  = 4'd2;
    localparam logic [3:0] S_SQJ  = 4'd3;
    localparam logic [3:0] S_MUL  = 4'd4;
    localparam logic [3:0] S_PREP = 4'd5;
    localparam logic [3:0] S_CHK  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_RES  = 4'd8;

    logic [3:0] r_state;
    logic [5:0] r_model_count;
    logic [8:0] r_dim_count;

    logic signed [15:0] r_mem [MEM_DEPTH];
    logic signed [15:0] r_rd_a;
    logic signed [15:0] r_rd_b;

    logic [4:0]          r_i;
    logic [4:0]          r_j;
    logic [DCNT_W-1:0]   r_d;
    logic                r_p1;
    logic                r_p2;
    logic signed [31:0]  r_pab;
    logic [30:0]         r_paa;
    logic [30:0]         r_pbb;
    logic signed [DOT_W-1:0] r_dot;
    logic [NORM_W-1:0]   r_ni;
    logic [NORM_W-1:0]   r_nj;
    logic [SQ_W-1:0]     r_si;
    logic [SQ_W-1:0]     r_sj;
    logic [DEN_W-1:0]    r_den;
    logic [WIDE_W-1:0]   r_num;
    logic [WIDE_W-1:0]   r_dsh;
    logic                r_neg;
    logic [14:0]         r_c;
    logic [QK_W-1:0]     r_qk;

    logic                r_out_valid;
    logic [4:0]          r_out_col;
    logic [15:0]         r_out_dist;
    logic                r_out_last;

    logic [4:0]  in_vec;
    logic [7:0]  in_dim;
    logic [15:0] in_elem;
    logic        in_acc;
    logic [5:0]  eff_n;
    logic [10:0] dc_ext;
    logic [DCNT_W-1:0] eff_d;
    logic        issue;
    logic        mac_done;
    logic [MEM_AW-1:0] addr_a;
    logic [MEM_AW-1:0] addr_b;
    logic [MEM_AW-1:0] addr_w;
    logic        load_ok;
    logic signed [31:0] m_ab;
    logic signed [31:0] m_aa;
    logic signed [31:0] m_bb;
    logic [DOT_W-1:0]  mag_full;
    logic [NORM_W-1:0] mag;
    logic        sq_start;
    logic [NORM_W-1:0] sq_value;
    logic        sq_done;
    logic [SQ_W-1:0]   sq_root;
    logic        out_free;
    logic        row_last;

    assign in_vec  = i_s_axis_tdata[4:0];
    assign in_dim  = i_s_axis_tdata[12:5];
    assign in_elem = i_s_axis_tdata[28:13];
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        if (r_model_count == 6'd0) begin
            eff_n = 6'd1;
        end else if (r_model_count > 6'(ROW_LIM)) begin
            eff_n = 6'(ROW_LIM);
        end else begin
            eff_n = r_model_count;
        end
        dc_ext = 11'(r_dim_count);
        if (dc_ext == 11'd0) begin
            eff_d = DCNT_W'(1);
        end else if (dc_ext > 11'(MAX_DIM)) begin
            eff_d = DCNT_W'(MAX_DIM);
        end else begin
            eff_d = DCNT_W'(dc_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_model_count <= 6'd32;
            r_dim_count   <= 9'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_MODEL_COUNT: r_model_count <= i_cfg_wdata[5:0];
                REG_DIM_COUNT:   r_dim_count   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // vector store, one write and two registered reads
    assign load_ok = (7'(in_vec) < 7'(MAX_VECTORS)) && (11'(in_dim) < 11'(MAX_DIM));
    assign addr_w  = {VEC_AW'(in_vec), DIM_AW'(in_dim)};
    assign addr_a  = {VEC_AW'(r_i), DIM_AW'(r_d)};
    assign addr_b  = {VEC_AW'(r_j), DIM_AW'(r_d)};

    always_ff @(posedge i_clk) begin
        if (in_acc && !i_s_axis_tuser && load_ok) begin
            r_mem[addr_w] <= in_elem;
        end
        r_rd_a <= r_mem[addr_a];
        r_rd_b <= r_mem[addr_b];
    end

    assign issue    = (r_state == S_MAC) && (r_d != eff_d);
    assign mac_done = (r_state == S_MAC) && !issue && !r_p1 && !r_p2;
    assign m_ab = r_rd_a * r_rd_b;
    assign m_aa = r_rd_a * r_rd_a;
    assign m_bb = r_rd_b * r_rd_b;
    assign mag_full = r_dot[DOT_W-1] ? DOT_W'(-r_dot) : DOT_W'(r_dot);
    assign mag      = mag_full[NORM_W-1:0];

    assign sq_start = (mac_done && (r_ni != '0) && (r_nj != '0))
                   || ((r_state == S_SQI) && sq_done);
    assign sq_value = (r_state == S_MAC) ? r_ni : r_nj;

    pcd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sq_start),
        .i_value (sq_value),
        .o_done  (sq_done),
        .o_root  (sq_root)
    );

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign row_last = (6'(r_j) + 6'd1) == eff_n;

    always_ff @(posedge i_clk) begin
        r_pab <= m_ab;
        r_paa <= m_aa[30:0];
        r_pbb <= m_bb[30:0];
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_p1        <= 1'b0;
            r_p2        <= 1'b0;
        end else begin
            r_p1 <= issue;
            r_p2 <= r_p1;
            if (r_out_valid && i_m_axis_tready && (r_state != S_RES)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_s_axis_tuser && (6'(in_vec) < eff_n)) begin
                        r_i     <= in_vec;
                        r_j     <= 5'd0;
                        r_d     <= '0;
                        r_dot   <= '0;
                        r_ni    <= '0;
                        r_nj    <= '0;
                        r_state <= S_MAC;
                    end
                end
                S_MAC: begin
                    if (issue) begin
                        r_d <= r_d + 1'b1;
                    end
                    if (r_p2) begin
                        r_dot <= r_dot + DOT_W'(r_pab);
                        r_ni  <= r_ni + NORM_W'(r_paa);
                        r_nj  <= r_nj + NORM_W'(r_pbb);
                    end
                    if (mac_done) begin
                        if ((r_ni == '0) || (r_nj == '0)) begin
                            r_c     <= '0;
                            r_neg   <= 1'b0;
                            r_state <= S_RES;
                        end else begin
                            r_state <= S_SQI;
                        end
                    end
                end
                S_SQI: begin
                    if (sq_done) begin
                        r_si    <= sq_root;
                        r_state <= S_SQJ;
                    end
                end
                S_SQJ: begin
                    if (sq_done) begin
                        r_sj    <= sq_root;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_den   <= DEN_W'(r_si * r_sj);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_num   <= (WIDE_W'(mag) << 15) + WIDE_W'(r_den);
                    r_dsh   <= WIDE_W'(r_den) << (QBITS + 1);
                    r_neg   <= r_dot[DOT_W-1];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_num >= r_dsh) begin
                        r_c     <= 15'(ONE_Q14);
                        r_state <= S_RES;
                    end else begin
                        r_c     <= '0;
                        r_dsh   <= r_dsh >> 1;
                        r_qk    <= QK_W'(QBITS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_num >= r_dsh) begin
                        r_num     <= r_num - r_dsh;
                        r_c[r_qk] <= 1'b1;
                    end
                    r_dsh <= r_dsh >> 1;
                    if (r_qk == '0) begin
                        r_state <= S_RES;
                    end else begin
                        r_qk <= r_qk - 1'b1;
                    end
                end
                S_RES: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_col   <= r_j;
                        r_out_dist  <= r_neg ? (ONE_Q14 + 16'(r_c)) : (ONE_Q14 - 16'(r_c));
                        r_out_last  <= row_last;
                        if (row_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_j     <= r_j + 5'd1;
                            r_d     <= '0;
                            r_dot   <= '0;
                            r_ni    <= '0;
                            r_nj    <= '0;
                            r_state <= S_MAC;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_dist, r_out_col};
    assign o_m_axis_tlast  = r_out_last;
endmodule

// ----- rtl/pcd_checker.sv -----
`timescale 1ns / 1ps
module pcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [23:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[20:5] <= 16'd32768)
        else $error("distance above 2.0");

    a_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !i_s_axis_tuser |=> o_s_axis_tready)
        else $error("load transfer left the unit busy");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready)
        else $error("reset did not empty the unit");
endmodule

bind pairwise_cosine_distance_unit pcd_checker u_pcd_checker (.*);

// ----- dv/pcd_distance_checker.sv -----
`timescale 1ns / 1ps
module pcd_distance_checker import pcd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [31:0] i_s_data,  // vec_index, dim_index, elem_value
    input  logic        i_s_user,  // req_type
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [23:0] i_m_data,  // col_index, distance
    input  logic        i_m_last,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [8:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct {
        logic [4:0]  col;
        logic [15:0] distance;
        logic        last;
    } t_distance;

    t_distance          expected_row[$];
    logic signed [15:0] vec_store [MAX_VECTORS][MAX_DIM];
    logic [5:0]         model_reg;
    logic [8:0]         dim_reg;

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [15:0] cosine_distance_q14(input int row, input int col,
                                                        input int dims);
        longint          dot;
        longint          ni;
        longint          nj;
        longint          a;
        longint          b;
        longint unsigned den;
        longint unsigned mag;
        longint unsigned c;
        dot = 0;
        ni  = 0;
        nj  = 0;
        for (int d = 0; d < dims; d++) begin
            a = vec_store[row][d];
            b = vec_store[col][d];
            dot += a * b;
            ni  += a * a;
            nj  += b * b;
        end
        if (ni == 0 || nj == 0) return ONE_Q14;
        den = floor_sqrt(ni) * floor_sqrt(nj);
        mag = (dot < 0) ? -dot : dot;
        c = (2 * (mag << 14) + den) / (2 * den);
        if (c > ONE_Q14) c = ONE_Q14;
        return (dot < 0) ? ONE_Q14 + c[15:0] : ONE_Q14 - c[15:0];
    endfunction

    always @(posedge i_clk) begin
        int        n;
        int        dims;
        int        row;
        t_distance e;
        if (!i_rst_n) begin
            model_reg = 6'd32;
            dim_reg   = 9'd256;
            expected_row.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_MODEL_COUNT) model_reg = i_cfg_wdata[5:0];
                else dim_reg = i_cfg_wdata;
            end
            if (i_s_valid && i_s_ready) begin
                if (!i_s_user) begin
                    vec_store[i_s_data[4:0]][i_s_data[12:5]] = i_s_data[28:13];
                end else begin
                    n    = (model_reg < 1) ? 1 : (model_reg > ROW_LIM) ? ROW_LIM : model_reg;
                    dims = (dim_reg < 1) ? 1 : (dim_reg > MAX_DIM) ? MAX_DIM : dim_reg;
                    row  = i_s_data[4:0];
                    if (row < n) begin
                        for (int j = 0; j < n; j++) begin
                            e.col      = j[4:0];
                            e.distance = cosine_distance_q14(row, j, dims);
                            e.last     = (j + 1 == n);
                            expected_row.push_back(e);
                        end
                    end
                end
            end
            if (i_m_valid && i_m_ready) begin
                if (expected_row.size() == 0) begin
                    $display("%0t unexpected result: expected none, got col %0d dist %0d",
                             $time, i_m_data[4:0], i_m_data[20:5]);
                    o_fail_count++;
                end else begin
                    e = expected_row.pop_front();
                    if (i_m_data[4:0] !== e.col) begin
                        $display("%0t col_index: expected %0d, got %0d",
                                 $time, e.col, i_m_data[4:0]);
                        o_fail_count++;
                    end
                    if (i_m_data[20:5] !== e.distance) begin
                        $display("%0t distance col %0d: expected %0d, got %0d",
                                 $time, e.col, e.distance, i_m_data[20:5]);
                        o_fail_count++;
                    end
                    if (i_m_last !== e.last) begin
                        $display("%0t last_in_row col %0d: expected %0d, got %0d",
                                 $time, e.col, e.last, i_m_last);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_row.size();
    end

endmodule

// ----- dv/pairwise_cosine_distance_unit_tb.sv -----
`timescale 1ns / 1ps
module pairwise_cosine_distance_unit_tb import pcd_pkg::*;;

    localparam int CYCLE_LIMIT = 3000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_data;
    logic        s_user;
    logic        m_valid;
    logic        m_ready;
    logic [23:0] m_data;
    logic        m_last;
    logic        cfg_we;
    logic        cfg_addr;
    logic [8:0]  cfg_wdata;

    int fail_count;
    int pending;
    int cycles;
    int hold_cycles;
    bit idle_on;
    bit written [MAX_VECTORS][MAX_DIM];

    pairwise_cosine_distance_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    pcd_distance_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_valid    (s_valid),
        .i_s_ready    (s_ready),
        .i_s_data     (s_data),
        .i_s_user     (s_user),
        .i_m_valid    (m_valid),
        .i_m_ready    (m_ready),
        .i_m_data     (m_data),
        .i_m_last     (m_last),
        .i_cfg_we     (cfg_we),
        .i_cfg_addr   (cfg_addr),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // result side, with a counted hold-off
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= !(idle_on && $urandom_range(99) < 18);
            end
        end
    end

    function automatic int elem_value();
        case ($urandom_range(7))
            0: return 0;
            1: return 32767;
            2: return -32768;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    task automatic send(input bit req, input int vec, input int dim, input int val);
        if (idle_on && $urandom_range(99) < 18) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= req;
        s_data  <= {3'b000, 16'(val), 8'(dim), 5'(vec)};
        if (!req) written[vec][dim] = 1'b1;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic addr, input int value);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= 9'(value);
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic run_phase(input int mc, input int dc, input int nrand, input bit hold);
        int n;
        int dims;
        int dim;
        drain();
        write_reg(REG_MODEL_COUNT, mc);
        write_reg(REG_DIM_COUNT, dc);
        n    = (mc % 64 < 1) ? 1 : (mc % 64 > ROW_LIM) ? ROW_LIM : mc % 64;
        dims = (dc % 512 < 1) ? 1 : (dc % 512 > MAX_DIM) ? MAX_DIM : dc % 512;
        for (int v = 0; v < n; v++)
            for (int d = 0; d < dims; d++)
                if (!written[v][d]) send(1'b0, v, d, elem_value());
        if (hold) hold_cycles = 3000;
        repeat (nrand) begin
            if ($urandom_range(99) < 70) begin
                dim = ($urandom_range(4) == 0) ? $urandom_range(255)
                                               : $urandom_range(dims - 1);
                send(1'b0, $urandom_range(31), dim, elem_value());
            end else begin
                send(1'b1, ($urandom_range(9) == 0) ? $urandom_range(31)
                                                    : $urandom_range(n - 1),
                     $urandom_range(255), $signed(16'($urandom)));
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        s_valid     = 1'b0;
        s_user      = 1'b0;
        s_data      = '0;
        cfg_we      = 1'b0;
        cfg_addr    = 1'b0;
        cfg_wdata   = '0;
        hold_cycles = 0;
        idle_on     = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // full-scale, negative full-scale, zero vector, mixed signs
        write_reg(REG_MODEL_COUNT, 4);
        write_reg(REG_DIM_COUNT, 4);
        for (int d = 0; d < 4; d++) begin
            send(1'b0, 0, d, 32767);
            send(1'b0, 1, d, -32768);
            send(1'b0, 2, d, 0);
        end
        send(1'b0, 3, 0, 32767);
        send(1'b0, 3, 1, -32768);
        send(1'b0, 3, 2, 1);
        send(1'b0, 3, 3, -1);
        for (int v = 0; v < 4; v++) send(1'b1, v, 255, -1);
        send(1'b1, 31, 0, 0);

        run_phase(0, 0, 10, 1'b0);
        idle_on = 1'b0;
        run_phase(63, 2, 30, 1'b1);
        idle_on = 1'b1;
        run_phase(1, 300, 4, 1'b0);
        send(1'b1, 31, 0, 0);
        send(1'b1, 0, 0, 0);
        run_phase($urandom_range(1, 32), $urandom_range(1, 2), 8, 1'b0);

        drain();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- pairwise_cosine_distance_unit.f -----
rtl/pcd_pkg.sv
rtl/pcd_sqrt.sv
rtl/pairwise_cosine_distance_unit.sv
rtl/pcd_checker.sv
dv/pcd_distance_checker.sv
dv/pairwise_cosine_distance_unit_tb.sv
